// ----- rtl/nnsa_pkg.sv -----
// ----------------------------------------------------------------------------
// nnsa_pkg - shared constants for the nearest neighbor scale address core
// Field widths, register index codes and default sizing of the datapath.
// ----------------------------------------------------------------------------
package nnsa_pkg;

	localparam int COORD_W        = 12;
	localparam int REG_W          = 13;
	localparam int REG_MAX        = (2 ** REG_W) - 1;
	localparam int INDEX_W        = 24;
	localparam int IN_DATA_W      = 2 * COORD_W;
	localparam int OUT_DATA_W     = 2 * COORD_W + INDEX_W;
	localparam int CFG_IDX_W      = 2;
	localparam int DEF_MAX_DIM    = 4096;
	// quotient bits resolved by each divider stage (the last stage may resolve fewer)
	localparam int BITS_PER_STAGE = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_WIDTH  = 2'd0,
		CFG_SOURCE_HEIGHT = 2'd1,
		CFG_DEST_WIDTH    = 2'd2,
		CFG_DEST_HEIGHT   = 2'd3
	} cfg_idx_t;

endpackage

// ----- rtl/nnsa_div_pipe.sv -----
// ----------------------------------------------------------------------------
// nnsa_div_pipe - pipelined restoring divider for one scaling axis
// Resolves up to BPS quotient bits per register stage; divisor is twice the size.
// ----------------------------------------------------------------------------
module nnsa_div_pipe
	import nnsa_pkg::*;
#(
	parameter int SZ_W   = 13,
	parameter int BPS    = BITS_PER_STAGE,
	parameter int STAGES = (SZ_W + BPS - 1) / BPS
) (
	input  logic              clk,
	input  logic [STAGES-1:0] en,
	input  logic [SZ_W-1:0]   size,
	input  logic [SZ_W:0]     rem_in,
	input  logic [SZ_W-1:0]   word_in,
	input  logic              ovf_in,
	output logic [SZ_W-1:0]   quo,
	output logic              ovf
);

	localparam int RW = SZ_W + 1;

	logic [RW-1:0]   div2;
	logic [RW-1:0]   rem_s  [STAGES];
	logic [SZ_W-1:0] word_s [STAGES];
	logic            ovf_s  [STAGES];

	assign div2 = {size, 1'b0};

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		logic [RW-1:0]   rem_prev;
		logic [SZ_W-1:0] word_prev;
		logic            ovf_prev;
		logic [RW-1:0]   rem_next;
		logic [SZ_W-1:0] word_next;

		if (j == 0) begin : g_first
			assign rem_prev  = rem_in;
			assign word_prev = word_in;
			assign ovf_prev  = ovf_in;
		end else begin : g_next
			assign rem_prev  = rem_s[j-1];
			assign word_prev = word_s[j-1];
			assign ovf_prev  = ovf_s[j-1];
		end

		// shift dividend bits out of the top of word, quotient bits in at the bottom
		always_comb begin
			logic [RW:0] trial;
			trial     = '0;
			rem_next  = rem_prev;
			word_next = word_prev;
			for (int b = 0; b < BPS; b++) begin
				if (j * BPS + b < SZ_W) begin
					trial     = {rem_next, word_next[SZ_W-1]};
					word_next = {word_next[SZ_W-2:0], 1'b0};
					if (trial >= {1'b0, div2}) begin
						trial        = trial - {1'b0, div2};
						word_next[0] = 1'b1;
					end
					rem_next = trial[RW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j]  <= rem_next;
				word_s[j] <= word_next;
				ovf_s[j]  <= ovf_prev;
			end
		end
	end

	assign quo = word_s[STAGES-1];
	assign ovf = ovf_s[STAGES-1];

endmodule

// ----- rtl/nearest_neighbor_scale_address_core.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_core - source address for nearest neighbor
// Maps a destination pixel to the source pixel and its row-major index.
// ----------------------------------------------------------------------------
// Usage:
//   Write source and destination sizes through cfg_we / cfg_index / cfg_wdata
//   while no request is in flight. A size of zero acts as one; a size above
//   MAX_DIM acts as MAX_DIM.
//   Each request on s_tdata carries one destination pixel (dest_x, dest_y).
//   Each response on m_tdata / m_tuser carries source_x, source_y,
//   source_index and out_of_range, in request order.
//   Pipeline at the default MAX_DIM: one multiply stage, one numerator stage,
//   seven divider stages of up to two quotient bits each, one clamp stage,
//   one index stage.
//   Throughput: one request per cycle while m_tready is high, set by the fully pipelined divider.
//   Reset empties the pipeline and sets all four sizes to one.
//   When the receiver stalls, the response holds in the output stage and the
//   stages behind it fill up; s_tready stays high while any stage is free,
//   so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_core
	import nnsa_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// write-only configuration port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]      cfg_wdata,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // dest_x, dest_y
	// response stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // source_x, source_y, source_index
	output logic                  m_tuser    // out_of_range
);

	// effective size range and datapath widths
	localparam int SZ_MAX     = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;
	localparam int SZ_W       = $clog2(SZ_MAX + 1);
	localparam int RW         = SZ_W + 1;
	localparam int PW         = COORD_W + SZ_W;
	localparam int NUM_W      = PW + 1;
	localparam int HI_W       = NUM_W - SZ_W;
	localparam int IXW        = (2 * SZ_W + 1 > INDEX_W) ? 2 * SZ_W + 1 : INDEX_W;
	localparam int DIV_STAGES = (SZ_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int NSTG       = DIV_STAGES + 4;
	localparam int ST_S1      = 0;
	localparam int ST_S2      = 1;
	localparam int ST_DIV     = 2;
	localparam int ST_S3      = DIV_STAGES + 2;
	localparam int ST_S4      = DIV_STAGES + 3;

	// ------------------------------------------------------------------
	// Configuration: store sizes already saturated to 1..SZ_MAX
	// ------------------------------------------------------------------
	function automatic logic [SZ_W-1:0] eff_size(input logic [REG_W-1:0] v);
		if (v == '0) begin
			eff_size = SZ_W'(1);
		end else if (32'(v) > SZ_MAX) begin
			eff_size = SZ_W'(SZ_MAX);
		end else begin
			eff_size = SZ_W'(v);
		end
	endfunction

	logic [SZ_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SZ_W'(1);
			src_h_q <= SZ_W'(1);
			dst_w_q <= SZ_W'(1);
			dst_h_q <= SZ_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE_WIDTH:  src_w_q <= eff_size(cfg_wdata);
				CFG_SOURCE_HEIGHT: src_h_q <= eff_size(cfg_wdata);
				CFG_DEST_WIDTH:    dst_w_q <= eff_size(cfg_wdata);
				CFG_DEST_HEIGHT:   dst_h_q <= eff_size(cfg_wdata);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: a stage advances when it is empty or the stage
	// after it advances, so bubbles close up behind a stalled response.
	// ------------------------------------------------------------------
	logic [NSTG-1:0] vld_s;
	logic [NSTG-1:0] rdy;

	always_comb begin
		logic full;
		for (int k = 0; k < NSTG; k++) begin
			full = 1'b1;
			for (int j = k; j < NSTG; j++) begin
				full = full & vld_s[j];
			end
			rdy[k] = m_tready | ~full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign s_tready = rdy[ST_S1];

	// ------------------------------------------------------------------
	// Stage 1: scale products dst * source_size, range flag
	// ------------------------------------------------------------------
	logic [COORD_W-1:0] dest_x, dest_y;
	logic [PW-1:0]      prod_x_s1, prod_y_s1;
	logic               oor_s1;

	assign dest_x = s_tdata[COORD_W-1:0];
	assign dest_y = s_tdata[2*COORD_W-1:COORD_W];

	always_ff @(posedge clk) begin
		if (rdy[ST_S1]) begin
			prod_x_s1 <= PW'(dest_x) * PW'(src_w_q);
			prod_y_s1 <= PW'(dest_y) * PW'(src_h_q);
			oor_s1    <= (PW'(dest_x) >= PW'(dst_w_q)) || (PW'(dest_y) >= PW'(dst_h_q));
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: numerator 2*dst*src + dst_size; flag quotients that cannot
	// fit SZ_W bits (they clamp anyway) and seed the divider remainder
	// ------------------------------------------------------------------
	logic [NUM_W-1:0] num_x, num_y;
	logic [HI_W-1:0]  hi_x, hi_y;
	logic [RW-1:0]    div2_x, div2_y;
	logic [RW-1:0]    rem_x_s2, rem_y_s2;
	logic [SZ_W-1:0]  word_x_s2, word_y_s2;
	logic             ovf_x_s2, ovf_y_s2, oor_s2;

	assign num_x  = {prod_x_s1, 1'b0} + NUM_W'(dst_w_q);
	assign num_y  = {prod_y_s1, 1'b0} + NUM_W'(dst_h_q);
	assign hi_x   = num_x[NUM_W-1:SZ_W];
	assign hi_y   = num_y[NUM_W-1:SZ_W];
	assign div2_x = {dst_w_q, 1'b0};
	assign div2_y = {dst_h_q, 1'b0};

	always_ff @(posedge clk) begin
		if (rdy[ST_S2]) begin
			rem_x_s2  <= RW'(hi_x);
			rem_y_s2  <= RW'(hi_y);
			word_x_s2 <= num_x[SZ_W-1:0];
			word_y_s2 <= num_y[SZ_W-1:0];
			ovf_x_s2  <= NUM_W'(hi_x) >= NUM_W'(div2_x);
			ovf_y_s2  <= NUM_W'(hi_y) >= NUM_W'(div2_y);
			oor_s2    <= oor_s1;
		end
	end

	// ------------------------------------------------------------------
	// Divider stages: one pipelined divider per axis, range flag alongside
	// ------------------------------------------------------------------
	logic [SZ_W-1:0] quo_x, quo_y;
	logic            ovf_x, ovf_y;
	logic            oor_sd [DIV_STAGES];

	nnsa_div_pipe #(
		.SZ_W   (SZ_W),
		.BPS    (BITS_PER_STAGE),
		.STAGES (DIV_STAGES)
	) u_div_x (
		.clk     (clk),
		.en      (rdy[ST_DIV +: DIV_STAGES]),
		.size    (dst_w_q),
		.rem_in  (rem_x_s2),
		.word_in (word_x_s2),
		.ovf_in  (ovf_x_s2),
		.quo     (quo_x),
		.ovf     (ovf_x)
	);

	nnsa_div_pipe #(
		.SZ_W   (SZ_W),
		.BPS    (BITS_PER_STAGE),
		.STAGES (DIV_STAGES)
	) u_div_y (
		.clk     (clk),
		.en      (rdy[ST_DIV +: DIV_STAGES]),
		.size    (dst_h_q),
		.rem_in  (rem_y_s2),
		.word_in (word_y_s2),
		.ovf_in  (ovf_y_s2),
		.quo     (quo_y),
		.ovf     (ovf_y)
	);

	always_ff @(posedge clk) begin
		if (rdy[ST_DIV]) begin
			oor_sd[0] <= oor_s2;
		end
		for (int j = 1; j < DIV_STAGES; j++) begin
			if (rdy[ST_DIV + j]) begin
				oor_sd[j] <= oor_sd[j-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: clamp each axis to source_size - 1
	// ------------------------------------------------------------------
	logic [SZ_W-1:0] lim_x, lim_y;
	logic [SZ_W-1:0] sx_s3, sy_s3;
	logic            oor_s3;

	assign lim_x = src_w_q - SZ_W'(1);
	assign lim_y = src_h_q - SZ_W'(1);

	always_ff @(posedge clk) begin
		if (rdy[ST_S3]) begin
			sx_s3  <= (ovf_x || (quo_x > lim_x)) ? lim_x : quo_x;
			sy_s3  <= (ovf_y || (quo_y > lim_y)) ? lim_y : quo_y;
			oor_s3 <= oor_sd[DIV_STAGES-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: row-major index; this stage is the output register
	// ------------------------------------------------------------------
	logic [IXW-1:0]     idx_full;
	logic [COORD_W-1:0] sx_s4, sy_s4;
	logic [INDEX_W-1:0] idx_s4;
	logic               oor_s4;

	assign idx_full = IXW'(sy_s3) * IXW'(src_w_q) + IXW'(sx_s3);

	always_ff @(posedge clk) begin
		if (rdy[ST_S4]) begin
			sx_s4  <= COORD_W'(sx_s3);
			sy_s4  <= COORD_W'(sy_s3);
			idx_s4 <= idx_full[INDEX_W-1:0];
			oor_s4 <= oor_s3;
		end
	end

	assign m_tvalid = vld_s[ST_S4];
	assign m_tdata  = {idx_s4, sy_s4, sx_s4};
	assign m_tuser  = oor_s4;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_S3] |-> (sx_s3 <= lim_x))
		else $error("source column beyond source width");

	a_clamp_y: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_S3] |-> (sy_s3 <= lim_y))
		else $error("source row beyond source height");

	a_seed_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[ST_S2] && !ovf_x_s2) |-> (rem_x_s2 < div2_x))
		else $error("divider seed remainder not below divisor");

	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request refused with empty output stage");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s[ST_S1])
		else $error("accepted request lost at first stage");

endmodule

// ----- test/tb_nearest_neighbor_scale_address_core.sv -----
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_scale_address_core - self-checking bench for the core
// Writes source and destination sizes, streams destination pixels and checks
// each returned source pixel, row-major index and out-of-range flag against
// an in-bench integer model, under several mixes of idle and backpressure.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_scale_address_core;
	import nnsa_pkg::*;

	localparam int MAX_DIM = DEF_MAX_DIM;
	// leave slack beyond the pipeline latency for stray responses
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_GUARD = 50000;
	localparam int REPORT_LIMIT = 10;

	typedef enum int {
		PACE_FULL,
		PACE_SRC_SLOW,
		PACE_SINK_SLOW,
		PACE_BOTH_SLOW
	} pace_t;

	typedef struct {
		logic [COORD_W-1:0] src_x;
		logic [COORD_W-1:0] src_y;
		logic [INDEX_W-1:0] src_index;
		logic               beyond;
	} src_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SOURCE_WIDTH;
	logic [REG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // dest_x, dest_y
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // source_x, source_y, source_index
	logic                  m_tuser;        // out_of_range

	pace_t pace = PACE_FULL;
	int    settings_used = 0;

	// A zero register acts as one, anything past MAX_DIM saturates.
	function automatic longint unsigned clip_size(input logic [REG_W-1:0] raw);
		if (raw == '0) return 1;
		if (raw > MAX_DIM) return MAX_DIM;
		return raw;
	endfunction

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Tracks the programmed sizes and the source pixels still owed by the core.
	class source_pixel_tracker;
		logic [REG_W-1:0] src_w = REG_W'(1);
		logic [REG_W-1:0] src_h = REG_W'(1);
		logic [REG_W-1:0] dst_w = REG_W'(1);
		logic [REG_W-1:0] dst_h = REG_W'(1);
		src_pixel_t owed_pixels[$];
		int requests = 0;
		int responses = 0;
		int errors = 0;

		function void set_size(cfg_idx_t idx, logic [REG_W-1:0] val);
			case (idx)
				CFG_SOURCE_WIDTH: src_w = val;
				CFG_SOURCE_HEIGHT: src_h = val;
				CFG_DEST_WIDTH: dst_w = val;
				CFG_DEST_HEIGHT: dst_h = val;
				default: ;
			endcase
		endfunction

		// round(d * s / n) with halves up, done exactly, then clamped to s-1
		function longint unsigned nearest(longint unsigned d, longint unsigned s,
				longint unsigned n);
			longint unsigned q;
			q = (2 * d * s + n) / (2 * n);
			if (q > s - 1) q = s - 1;
			return q;
		endfunction

		function void note_request(logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy);
			longint unsigned sw, sh, dw, dh, sx, sy;
			src_pixel_t pix;
			sw = clip_size(src_w);
			sh = clip_size(src_h);
			dw = clip_size(dst_w);
			dh = clip_size(dst_h);
			sx = nearest(dx, sw, dw);
			sy = nearest(dy, sh, dh);
			pix.src_x = sx[COORD_W-1:0];
			pix.src_y = sy[COORD_W-1:0];
			pix.src_index = INDEX_W'(sy * sw + sx);
			pix.beyond = (dx >= dw) || (dy >= dh);
			owed_pixels = {owed_pixels, pix};
			requests++;
		endfunction

		function void check_response(logic [OUT_DATA_W-1:0] data, logic flag);
			src_pixel_t want;
			bit bad;
			responses++;
			if (owed_pixels.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("ERROR: response %0d arrived with no request pending, data %h user %b",
						responses, data, flag);
				return;
			end
			want = owed_pixels.pop_front();
			bad = 1'b0;
			if (data[COORD_W-1:0] !== want.src_x) bad = 1'b1;
			if (data[2*COORD_W-1:COORD_W] !== want.src_y) bad = 1'b1;
			if (data[OUT_DATA_W-1:2*COORD_W] !== want.src_index) bad = 1'b1;
			if (flag !== want.beyond) bad = 1'b1;
			if (bad) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("ERROR: response %0d x %0d/%0d y %0d/%0d index %0d/%0d oor %b/%b (exp/got)",
						responses, want.src_x, data[COORD_W-1:0],
						want.src_y, data[2*COORD_W-1:COORD_W],
						want.src_index, data[OUT_DATA_W-1:2*COORD_W],
						want.beyond, flag);
			end
		endfunction

		function int pending();
			return owed_pixels.size();
		endfunction
	endclass

	source_pixel_tracker tracker;

	nearest_neighbor_scale_address_core #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check whatever the core hands over at this edge, then pick the next ready.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) tracker.check_response(m_tdata, m_tuser);
		case (pace)
			PACE_SINK_SLOW: m_tready <= !roll(84);
			PACE_BOTH_SLOW: m_tready <= !roll(17);
			default: m_tready <= 1'b1;
		endcase
	end

	// Hold one size register write for a single edge; the caller drops cfg_we.
	task automatic write_reg(input cfg_idx_t idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.set_size(idx, val);
	endtask

	// Only call while nothing is in flight.
	task automatic set_sizes(input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh,
			input logic [REG_W-1:0] dw, input logic [REG_W-1:0] dh);
		write_reg(CFG_SOURCE_WIDTH, sw);
		write_reg(CFG_SOURCE_HEIGHT, sh);
		write_reg(CFG_DEST_WIDTH, dw);
		write_reg(CFG_DEST_HEIGHT, dh);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Idle for a while if the pace asks for it, then present one request
	// and hold it until the core takes it.
	task automatic send_request(input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
		int gap_pct;
		gap_pct = (pace == PACE_SRC_SLOW) ? 84 : (pace == PACE_BOTH_SLOW) ? 17 : 0;
		while (roll(gap_pct)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dy, dx};
		do @(posedge clk); while (!s_tready);
		tracker.note_request(dx, dy);
	endtask

	// Advance until every owed response has come back, with a guard.
	task automatic wait_for_results();
		int guard;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (tracker.pending() != 0 && guard < DRAIN_GUARD);
	endtask

	// Drop valid after the last accepted request and drain the pipeline.
	task automatic close_burst();
		s_tvalid <= 1'b0;
		wait_for_results();
	endtask

	// Mostly coordinates inside the destination, plus its edges and noise.
	function automatic logic [COORD_W-1:0] pick_coord(input logic [REG_W-1:0] size_reg);
		longint unsigned lim;
		int r;
		lim = clip_size(size_reg);
		r = $urandom_range(0, 99);
		if (r < 70) return COORD_W'($urandom_range(0, int'(lim) - 1));
		if (r < 80) return COORD_W'(lim - 1);
		if (r < 90) return (lim > 4095) ? '1 : COORD_W'(lim);
		return COORD_W'($urandom_range(0, 4095));
	endfunction

	function automatic logic [REG_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 16) return REG_W'($urandom_range(MAX_DIM + 1, REG_MAX));
		if (r < 50) return REG_W'($urandom_range(1, 64));
		return REG_W'($urandom_range(1, MAX_DIM));
	endfunction

	// One programmed size setting followed by random requests.
	task automatic run_phase(input logic [REG_W-1:0] sw, input logic [REG_W-1:0] sh,
			input logic [REG_W-1:0] dw, input logic [REG_W-1:0] dh,
			input pace_t p, input int count, input bit hold_mid);
		pace = p;
		set_sizes(sw, sh, dw, dh);
		for (int i = 0; i < count; i++) begin
			// hold the sender until the core has answered everything
			if (hold_mid && i == count / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (tracker.pending() != 0);
			end
			send_request(pick_coord(dw), pick_coord(dh));
		end
		close_burst();
	endtask

	initial begin
		tracker = new;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes are all one: every pixel maps to the origin
		send_request(12'd0, 12'd0);
		send_request(12'hFFF, 12'hFFF);
		send_request(12'd1, 12'd0);
		close_burst();

		// largest sizes, identity mapping, alternating bit patterns
		set_sizes(REG_W'(MAX_DIM), REG_W'(MAX_DIM), REG_W'(MAX_DIM), REG_W'(MAX_DIM));
		send_request(12'd0, 12'd0);
		send_request(12'hFFF, 12'hFFF);
		send_request(12'hFFF, 12'd0);
		send_request(12'd0, 12'hFFF);
		send_request(12'hAAA, 12'h555);
		send_request(12'h555, 12'hAAA);
		close_burst();

		// zero source width acts as one, oversized source height saturates;
		// a row past a one-pixel destination still maps and clamps
		set_sizes('0, REG_W'(REG_MAX), 13'd3, 13'd1);
		send_request(12'd0, 12'd0);
		send_request(12'd1, 12'd0);
		send_request(12'd2, 12'd0);
		send_request(12'd3, 12'd0);
		send_request(12'd0, 12'd1);
		close_burst();

		// exact halves must round up: 1*7/2 = 3.5 and 1*5/2 = 2.5
		set_sizes(13'd7, 13'd5, 13'd2, 13'd2);
		send_request(12'd0, 12'd0);
		send_request(12'd1, 12'd1);
		send_request(12'd1, 12'd0);
		send_request(12'd2, 12'd2);
		close_burst();

		run_phase(13'd640, 13'd480, 13'd1920, 13'd1080, PACE_FULL, 80, 1'b0);
		run_phase(13'd1920, 13'd1080, 13'd640, 13'd480, PACE_SRC_SLOW, 80, 1'b1);
		run_phase(REG_W'(MAX_DIM), REG_W'(MAX_DIM), 13'd1, 13'd1, PACE_SINK_SLOW, 60, 1'b0);
		run_phase(13'd1, 13'd1, REG_W'(MAX_DIM), REG_W'(MAX_DIM), PACE_BOTH_SLOW, 60, 1'b0);
		for (int k = 0; k < 6; k++)
			run_phase(pick_size(), pick_size(), pick_size(), pick_size(),
				pace_t'(k % 4), 62, 1'b0);

		// catch anything the core emits after the last owed response
		pace = PACE_FULL;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.pending() != 0) begin
			tracker.errors++;
			$display("ERROR: %0d responses never arrived", tracker.pending());
		end

		$display("Sent %0d destination pixels over %0d size settings, got %0d responses,",
			tracker.requests, settings_used, tracker.responses);
		$display("with zero, saturated and rounding sizes under idle and backpressure.");
		if (tracker.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d errors", tracker.errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/nnsa_pkg.sv
rtl/nnsa_div_pipe.sv
rtl/nearest_neighbor_scale_address_core.sv
test/tb_nearest_neighbor_scale_address_core.sv
